// ----- rtl/pbwd_pkg.sv -----
// shared types and constants of the protobuf wire field decoder
`default_nettype none

package pbwd_pkg;

   // wire type codes
   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LEN     = 3'd2;
   localparam logic [2:0] WIRE_SGROUP  = 3'd3;
   localparam logic [2:0] WIRE_EGROUP  = 3'd4;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   // result kinds
   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // tenth base-128 group ends a varint regardless of its continuation bit
   localparam logic [3:0] VARINT_LAST_GROUP = 4'd9;

   // result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = 2;
   localparam int unsigned FIFO_CW    = 3;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VARINT,
      PH_FIXED,
      PH_LENLEN,
      PH_PAYLOAD,
      PH_HALT
   } pbwd_phase_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] field_num;
      logic [2:0]  wire_code;
      logic [63:0] value;
      logic [7:0]  payload_byte;
      logic        truncated;
      logic        run_last;
   } pbwd_result_type;

   // up to two results per input item, first slot fills first
   typedef struct packed {
      logic            valid0;
      logic            valid1;
      pbwd_result_type res0;
      pbwd_result_type res1;
   } pbwd_issue_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      logic [31:0] data;
   } pbwd_stack_cmd_type;

   typedef struct packed {
      logic        full;
      logic        empty;
      logic [31:0] top;
   } pbwd_stack_status_type;

endpackage

`default_nettype wire

// ----- rtl/pbwd_group_stack.sv -----
// bounded stack of open group field numbers, top held in a register
`default_nettype none

module pbwd_group_stack
   import pbwd_pkg::*;
#(
   parameter int unsigned MAX_GROUP_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pbwd_stack_cmd_type    cmd,
   output pbwd_stack_status_type      status
);

   localparam int unsigned DW = $clog2(MAX_GROUP_DEPTH + 1);
   localparam int unsigned AW = (MAX_GROUP_DEPTH > 1) ? $clog2(MAX_GROUP_DEPTH) : 1;

   logic [31:0]   mem [2**AW];
   logic [DW-1:0] depth_ff;
   logic [DW-1:0] depth_in;
   logic [31:0]   top_ff;
   logic [31:0]   below_ff;
   logic [DW-1:0] wr_sum;
   logic [DW-1:0] rd_sum;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   // entries below the top live in memory; below_ff tracks the one under the top
   assign wr_sum  = depth_ff - DW'(1);
   assign wr_addr = wr_sum[AW-1:0];
   assign wr_en   = cmd.push && (depth_ff != '0);

   always_comb begin
      depth_in = depth_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
      end else if (cmd.pop) begin
         depth_in = depth_ff - DW'(1);
      end
   end

   assign rd_sum  = depth_in - DW'(2);
   assign rd_addr = rd_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         top_ff <= cmd.data;
      end else if (cmd.pop) begin
         top_ff <= below_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= mem[rd_addr];
      end
   end

   assign status.full  = (depth_ff == DW'(MAX_GROUP_DEPTH));
   assign status.empty = (depth_ff == '0);
   assign status.top   = top_ff;

endmodule

`default_nettype wire

// ----- rtl/pbwd_decode.sv -----
// byte decoder: parse state and result generation for one item per cycle while take is high
`default_nettype none

module pbwd_decode
   import pbwd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  last_byte,
   input  wire pbwd_stack_status_type stk,
   output pbwd_stack_cmd_type         stk_cmd,
   output pbwd_issue_type             issue
);

   pbwd_phase_type phase_ff, phase_in;
   logic [63:0]    accum_ff, accum_in;
   logic [3:0]     group_ff, group_in;
   logic [2:0]     seen_ff, seen_in;
   logic [31:0]    field_ff, field_in;
   logic [2:0]     wire_ff, wire_in;
   logic [63:0]    left_ff, left_in;

   logic [5:0]     shamt;
   logic [63:0]    var_acc;
   logic           var_done;
   logic [31:0]    tag_field;
   logic [2:0]     tag_wire;
   logic           tag_end;
   logic           grp_match;
   logic [63:0]    fix_acc;
   logic           fix_met;
   logic [63:0]    left_dec;
   logic           left_zero;

   assign shamt     = 6'({2'b00, group_ff} * 6'd7);
   assign var_acc   = accum_ff | (64'(data_byte[6:0]) << shamt);
   assign var_done  = !data_byte[7] || (group_ff == VARINT_LAST_GROUP);
   assign tag_field = var_acc[34:3];
   assign tag_wire  = var_acc[2:0];
   assign tag_end   = var_done || last_byte;
   assign grp_match = !stk.empty && (stk.top == tag_field);
   assign fix_acc   = accum_ff | (64'(data_byte) << {seen_ff, 3'b000});
   assign fix_met   = (wire_ff == WIRE_FIXED64) ? (seen_ff == 3'd7) : (seen_ff == 3'd3);
   assign left_dec  = (left_ff != '0) ? left_ff - 64'd1 : left_ff;
   assign left_zero = (left_dec == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_TAG: begin
               if (tag_end) begin
                  unique case (tag_wire)
                     WIRE_SGROUP:  phase_in = stk.full ? PH_HALT : PH_TAG;
                     WIRE_EGROUP:  phase_in = grp_match ? PH_TAG : PH_HALT;
                     WIRE_VARINT:  phase_in = last_byte ? PH_TAG : PH_VARINT;
                     WIRE_LEN:     phase_in = last_byte ? PH_TAG : PH_LENLEN;
                     WIRE_FIXED64,
                     WIRE_FIXED32: phase_in = last_byte ? PH_TAG : PH_FIXED;
                     default:      phase_in = PH_HALT;
                  endcase
               end
            end
            PH_VARINT: begin
               if (var_done) begin
                  phase_in = PH_TAG;
               end
            end
            PH_LENLEN: begin
               if (var_done) begin
                  if (var_acc == '0) begin
                     phase_in = PH_TAG;
                  end else if (!last_byte) begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_FIXED: begin
               if (fix_met) begin
                  phase_in = PH_TAG;
               end
            end
            PH_PAYLOAD: begin
               if (left_zero) begin
                  phase_in = PH_TAG;
               end
            end
            PH_HALT: phase_in = PH_HALT;
            default: phase_in = PH_TAG;
         endcase
         if (last_byte) begin
            phase_in = PH_TAG;
         end
      end
   end

   // datapath state, results and stack commands
   always_comb begin
      accum_in = accum_ff;
      group_in = group_ff;
      seen_in  = seen_ff;
      field_in = field_ff;
      wire_in  = wire_ff;
      left_in  = left_ff;

      issue.valid0            = 1'b0;
      issue.valid1            = 1'b0;
      issue.res0.kind         = KIND_RECORD;
      issue.res0.field_num    = field_ff;
      issue.res0.wire_code    = wire_ff;
      issue.res0.value        = '0;
      issue.res0.payload_byte = '0;
      issue.res0.truncated    = 1'b0;
      issue.res0.run_last     = 1'b0;
      issue.res1              = issue.res0;

      stk_cmd.push  = 1'b0;
      stk_cmd.pop   = 1'b0;
      stk_cmd.clear = take && last_byte;
      stk_cmd.data  = tag_field;

      if (take) begin
         unique case (phase_ff)
            PH_TAG: begin
               if (tag_end) begin
                  accum_in = '0;
                  group_in = '0;
                  seen_in  = '0;
                  field_in = tag_field;
                  wire_in  = tag_wire;
                  issue.res0.field_num = tag_field;
                  issue.res0.wire_code = tag_wire;
                  unique case (tag_wire)
                     WIRE_SGROUP: begin
                        stk_cmd.push = !stk.full;
                     end
                     WIRE_EGROUP: begin
                        stk_cmd.pop          = grp_match;
                        issue.valid0         = !grp_match;
                        issue.res0.truncated = !var_done;
                     end
                     WIRE_VARINT, WIRE_LEN, WIRE_FIXED64, WIRE_FIXED32: begin
                        // field cut right after its tag
                        issue.valid0         = last_byte;
                        issue.res0.truncated = 1'b1;
                     end
                     default: begin
                        issue.valid0         = 1'b1;
                        issue.res0.truncated = !var_done;
                     end
                  endcase
               end else begin
                  accum_in = var_acc;
                  group_in = group_ff + 4'd1;
               end
            end
            PH_VARINT: begin
               issue.res0.value = var_acc;
               if (var_done) begin
                  issue.valid0 = 1'b1;
                  accum_in     = '0;
                  group_in     = '0;
               end else begin
                  issue.valid0         = last_byte;
                  issue.res0.truncated = 1'b1;
                  accum_in             = var_acc;
                  group_in             = group_ff + 4'd1;
               end
            end
            PH_LENLEN: begin
               issue.res0.value = var_acc;
               if (var_done) begin
                  group_in = '0;
                  if (var_acc == '0) begin
                     issue.valid0 = 1'b1;
                     accum_in     = '0;
                  end else begin
                     issue.valid0         = last_byte;
                     issue.res0.truncated = 1'b1;
                     accum_in             = var_acc;
                     left_in              = var_acc;
                  end
               end else begin
                  issue.valid0         = last_byte;
                  issue.res0.truncated = 1'b1;
                  accum_in             = var_acc;
                  group_in             = group_ff + 4'd1;
               end
            end
            PH_FIXED: begin
               if (fix_met) begin
                  issue.valid0     = 1'b1;
                  issue.res0.value = fix_acc;
                  seen_in          = '0;
                  accum_in         = '0;
               end else begin
                  issue.valid0         = last_byte;
                  issue.res0.truncated = 1'b1;
                  seen_in              = seen_ff + 3'd1;
                  accum_in             = fix_acc;
               end
            end
            PH_PAYLOAD: begin
               issue.valid0            = 1'b1;
               issue.res0.kind         = KIND_PAYLOAD;
               issue.res0.payload_byte = data_byte;
               issue.res1.value        = accum_ff;
               left_in                 = left_dec;
               if (left_zero) begin
                  issue.valid1 = 1'b1;
                  accum_in     = '0;
               end else begin
                  issue.valid1         = last_byte;
                  issue.res1.truncated = 1'b1;
               end
            end
            PH_HALT: begin
               accum_in = accum_ff;
            end
            default: begin
               accum_in = accum_ff;
            end
         endcase

         if (issue.valid1) begin
            issue.res1.run_last = 1'b1;
         end else begin
            issue.res0.run_last = 1'b1;
         end

         // end of buffer drops all message state
         if (last_byte) begin
            accum_in = '0;
            group_in = '0;
            seen_in  = '0;
            field_in = '0;
            wire_in  = '0;
            left_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         accum_ff <= '0;
         group_ff <= '0;
         seen_ff  <= '0;
         field_ff <= '0;
         wire_ff  <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         group_ff <= group_in;
         seen_ff  <= seen_in;
         field_ff <= field_in;
         wire_ff  <= wire_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pbwd_out_fifo.sv -----
// result queue: takes up to two results per cycle, delivers one while out_stall is low
`default_nettype none

module pbwd_out_fifo
   import pbwd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pbwd_issue_type  issue,
   output logic                 room,
   output logic                 out_valid,
   input  wire logic            out_stall,
   output pbwd_result_type      out_res
);

   pbwd_result_type      slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wp_ff, wp_in;
   logic [FIFO_AW-1:0]   rp_ff, rp_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic [FIFO_AW-1:0]   wp_next;
   logic                 pop;

   assign wp_next   = wp_ff + FIFO_AW'(1);
   assign out_valid = (count_ff != '0);
   assign out_res   = slot_ff[rp_ff];
   assign pop       = out_valid && !out_stall;
   // an item may bring two results
   assign room      = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      if (issue.valid1) begin
         wp_in    = wp_ff + FIFO_AW'(2);
         count_in = count_in + FIFO_CW'(2);
      end else if (issue.valid0) begin
         wp_in    = wp_next;
         count_in = count_in + FIFO_CW'(1);
      end
      if (pop) begin
         rp_in    = rp_ff + FIFO_AW'(1);
         count_in = count_in - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid0) begin
         slot_ff[wp_ff] <= issue.res0;
      end
      if (issue.valid1) begin
         slot_ff[wp_next] <= issue.res1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/protobuf_wire_field_decoder.sv -----
// top level of the protobuf wire field decoder
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  data_byte, last_byte
//   rsp_      out         rsp_valid/rsp_stall  kind .. run_last (one result each)
//
// one byte is decoded per cycle while req_stall is low; its results are registered in the result queue
// the last payload byte of a length-delimited field yields two results, drained
// one per cycle while rsp_stall is low from a four-entry result queue
// req_stall rises while the queue has fewer than two free entries
// synchronous reset returns the parser to tag reading with no groups open
`default_nettype none

module protobuf_wire_field_decoder
   import pbwd_pkg::*;
#(
   parameter int unsigned MAX_GROUP_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [31:0]      rsp_field_num,
   output logic [2:0]       rsp_wire_code,
   output logic [63:0]      rsp_value,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_truncated,
   output logic             rsp_run_last
);

   pbwd_stack_cmd_type    stk_cmd;
   pbwd_stack_status_type stk_status;
   pbwd_issue_type        issue;
   pbwd_result_type       out_res;
   logic                  room;
   logic                  take;

   assign req_stall = !room;
   assign take      = req_valid && room;

   pbwd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .stk       (stk_status),
      .stk_cmd   (stk_cmd),
      .issue     (issue)
   );

   pbwd_group_stack #(
      .MAX_GROUP_DEPTH (MAX_GROUP_DEPTH)
   ) u_group_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stk_cmd),
      .status (stk_status)
   );

   pbwd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_field_num    = out_res.field_num;
   assign rsp_wire_code    = out_res.wire_code;
   assign rsp_value        = out_res.value;
   assign rsp_payload_byte = out_res.payload_byte;
   assign rsp_truncated    = out_res.truncated;
   assign rsp_run_last     = out_res.run_last;

endmodule

`default_nettype wire

// ----- dv/tb_protobuf_wire_field_decoder.sv -----
// self-checking testbench for the protobuf wire field decoder
`timescale 1ns / 100ps

module tb_protobuf_wire_field_decoder
   import pbwd_pkg::*;
();

   localparam int unsigned GROUP_DEPTH  = 16;
   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned TAIL_CYCLES  = 16;
   localparam int unsigned CALM_FROM    = 600;
   localparam int unsigned CALM_TO      = 850;
   localparam logic [2:0]  WIRE_BAD6    = 3'd6;
   localparam logic [2:0]  WIRE_BAD7    = 3'd7;

   // {last_byte, data_byte}
   localparam logic [8:0] DIRECTED [26] = '{
      9'h00A, 9'h001, 9'h0FF, 9'h012, 9'h000, 9'h00B, 9'h00C, 9'h01E, 9'h000, 9'h101,
      9'h00D, 9'h000, 9'h0FF, 9'h080, 9'h07F, 9'h009, 9'h0FF, 9'h1FF,
      9'h10C,
      9'h180,
      9'h008, 9'h1FF,
      9'h012, 9'h003, 9'h141,
      9'h115
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [31:0] rsp_field_num;
   logic [2:0]  rsp_wire_code;
   logic [63:0] rsp_value;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_truncated;
   logic        rsp_run_last;

   wire req_take = req_valid && !req_stall;
   wire rsp_take = rsp_valid && !rsp_stall;
   pbwd_result_type rsp_seen;
   assign rsp_seen = {rsp_kind, rsp_field_num, rsp_wire_code, rsp_value,
                      rsp_payload_byte, rsp_truncated, rsp_run_last};

   bit          calm = 1'b0;
   int unsigned sent_count = 0;
   logic [7:0]  msg_q[$];
   logic [31:0] open_q[$];

   protobuf_wire_field_decoder #(.MAX_GROUP_DEPTH(GROUP_DEPTH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_field_num(rsp_field_num),
      .rsp_wire_code(rsp_wire_code),
      .rsp_value(rsp_value),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_truncated(rsp_truncated),
      .rsp_run_last(rsp_run_last)
   );

   class field_record_book;
      pbwd_phase_type  phase;
      logic [63:0]     accum;
      int unsigned     shift;
      int unsigned     fixed_seen;
      logic [31:0]     cur_field;
      logic [2:0]      cur_wire;
      logic [63:0]     bytes_left;
      logic [31:0]     group_stack [GROUP_DEPTH];
      int unsigned     depth;
      pbwd_result_type pending_records[$];
      pbwd_result_type held;
      bit              have_held;
      int unsigned     fails;

      function new();
         clear_message();
         have_held = 1'b0;
         fails = 0;
      endfunction

      function void clear_message();
         phase = PH_TAG;
         accum = '0;
         shift = 0;
         fixed_seen = 0;
         cur_field = '0;
         cur_wire = '0;
         bytes_left = '0;
         depth = 0;
      endfunction

      // results of one byte are held back one step so the final one gets run_last
      function void emit(logic kind, logic [63:0] val, logic [7:0] pb, logic trunc);
         if (have_held) pending_records = {pending_records, held};
         held = '{kind: kind, field_num: cur_field, wire_code: cur_wire, value: val,
                  payload_byte: pb, truncated: trunc, run_last: 1'b0};
         have_held = 1'b1;
      endfunction

      function bit take_group(logic [7:0] b);
         bit done;
         if (shift < 64) accum |= 64'(b[6:0]) << shift;
         done = !b[7] || (shift + 7 >= 64);
         shift = done ? 0 : shift + 7;
         return done;
      endfunction

      function void open_field(logic [63:0] tag, bit cut, bit last);
         cur_field = tag[34:3];
         cur_wire = tag[2:0];
         accum = '0;
         shift = 0;
         fixed_seen = 0;
         case (cur_wire)
            WIRE_SGROUP: begin
               if (depth < GROUP_DEPTH) begin
                  group_stack[depth] = cur_field;
                  depth++;
                  phase = PH_TAG;
               end else begin
                  phase = PH_HALT;
               end
            end
            WIRE_EGROUP: begin
               if (depth > 0 && group_stack[depth-1] == cur_field) begin
                  depth--;
                  phase = PH_TAG;
               end else begin
                  emit(KIND_RECORD, '0, '0, cut);
                  phase = PH_HALT;
               end
            end
            WIRE_BAD6, WIRE_BAD7: begin
               emit(KIND_RECORD, '0, '0, cut);
               phase = PH_HALT;
            end
            default: begin
               if (last) begin
                  emit(KIND_RECORD, '0, '0, 1'b1);
                  phase = PH_TAG;
               end else if (cur_wire == WIRE_VARINT) begin
                  phase = PH_VARINT;
               end else if (cur_wire == WIRE_LEN) begin
                  phase = PH_LENLEN;
               end else begin
                  phase = PH_FIXED;
               end
            end
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         bit done;
         int unsigned need;
         case (phase)
            PH_TAG: begin
               done = take_group(b);
               if (done || last) begin
                  shift = 0;
                  open_field(accum, !done, last);
               end
            end
            PH_VARINT: begin
               done = take_group(b);
               if (done) begin
                  emit(KIND_RECORD, accum, '0, 1'b0);
                  phase = PH_TAG;
               end else if (last) begin
                  emit(KIND_RECORD, accum, '0, 1'b1);
               end
            end
            PH_LENLEN: begin
               done = take_group(b);
               if (done) begin
                  if (accum == '0) begin
                     emit(KIND_RECORD, '0, '0, 1'b0);
                     phase = PH_TAG;
                  end else if (last) begin
                     emit(KIND_RECORD, accum, '0, 1'b1);
                  end else begin
                     bytes_left = accum;
                     phase = PH_PAYLOAD;
                  end
               end else if (last) begin
                  emit(KIND_RECORD, accum, '0, 1'b1);
               end
            end
            PH_FIXED: begin
               need = (cur_wire == WIRE_FIXED64) ? 8 : 4;
               if (fixed_seen < 8) accum |= 64'(b) << (8 * fixed_seen);
               fixed_seen++;
               if (fixed_seen >= need) begin
                  emit(KIND_RECORD, accum, '0, 1'b0);
                  fixed_seen = 0;
                  phase = PH_TAG;
               end else if (last) begin
                  emit(KIND_RECORD, '0, '0, 1'b1);
               end
            end
            PH_PAYLOAD: begin
               emit(KIND_PAYLOAD, '0, b, 1'b0);
               if (bytes_left != '0) bytes_left--;
               if (bytes_left == '0) begin
                  emit(KIND_RECORD, accum, '0, 1'b0);
                  phase = PH_TAG;
               end else if (last) begin
                  emit(KIND_RECORD, accum, '0, 1'b1);
               end
            end
            default: ;
         endcase
         if (phase == PH_TAG && have_held) begin
            accum = '0;
            shift = 0;
         end
         if (last) clear_message();
         if (have_held) begin
            held.run_last = 1'b1;
            pending_records = {pending_records, held};
            have_held = 1'b0;
         end
      endfunction

      function bit differs(string name, logic [63:0] want, logic [63:0] seen);
         if (seen === want) return 1'b0;
         $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, seen);
         return 1'b1;
      endfunction

      function void check_record(pbwd_result_type got);
         pbwd_result_type want;
         bit bad;
         if (pending_records.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %0h", $time, got);
            fails++;
            return;
         end
         want = pending_records.pop_front();
         bad = differs("kind", 64'(want.kind), 64'(got.kind));
         bad |= differs("field_num", 64'(want.field_num), 64'(got.field_num));
         bad |= differs("wire_code", 64'(want.wire_code), 64'(got.wire_code));
         bad |= differs("value", want.value, got.value);
         bad |= differs("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
         bad |= differs("truncated", 64'(want.truncated), 64'(got.truncated));
         bad |= differs("run_last", 64'(want.run_last), 64'(got.run_last));
         if (bad) fails++;
      endfunction

      function int unsigned pending();
         return pending_records.size();
      endfunction
   endclass

   field_record_book book = new();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(0, 99) < 33);

   // outputs are sampled mid-cycle, where they hold for the coming edge
   always @(negedge clock)
      if (!reset && rsp_take) book.check_record(rsp_seen);

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if (req_take || rsp_take) quiet = 0;
         else quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 4))
         0: return 64'($urandom_range(0, 127));
         1: return {32'd0, $urandom};
         2: return {$urandom, $urandom};
         3: return '1;
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0, 1: return 32'($urandom_range(1, 15));
         2: return 32'($urandom_range(16, 1 << 20));
         3: return $urandom;
         4: return '1;
         default: return '0;
      endcase
   endfunction

   // base-128 encoding, optionally padded with redundant groups up to ten
   function automatic void add_varint(logic [63:0] v, int unsigned pad);
      int unsigned n;
      logic [6:0] grp;
      logic more;
      n = 1;
      while (n < 10 && (v >> (7 * n)) != '0) n++;
      n = (n + pad > 10) ? 10 : n + pad;
      for (int unsigned i = 0; i < n; i++) begin
         grp = 7'(v >> (7 * i));
         more = (i < n - 1);
         if (i == 9) begin
            // bits past 63 and the tenth continuation bit are ignored
            grp[6:1] = 6'($urandom);
            if ($urandom_range(0, 3) == 0) more = 1'b1;
         end
         msg_q = {msg_q, {more, grp}};
      end
   endfunction

   function automatic void add_tag(logic [31:0] f, logic [2:0] w);
      logic [63:0] tag;
      tag = {29'd0, f, w};
      if ($urandom_range(0, 7) == 0) tag[63:35] = 29'({$urandom, $urandom});
      add_varint(tag, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
   endfunction

   function automatic void add_bytes(int unsigned n);
      repeat (n) msg_q = {msg_q, 8'($urandom)};
   endfunction

   function automatic void close_groups();
      while (open_q.size() > 0) add_tag(open_q.pop_back(), WIRE_EGROUP);
   endfunction

   function automatic void add_field();
      logic [31:0] f;
      int unsigned k;
      int unsigned len;
      f = rand_field();
      k = $urandom_range(0, 99);
      if (k < 22 || (k >= 82 && k < 94 && open_q.size() == 0) || k >= 98) begin
         add_tag(f, WIRE_VARINT);
         add_varint(rand_value(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0);
      end else if (k < 34) begin
         add_tag(f, WIRE_FIXED64);
         add_bytes(8);
      end else if (k < 46) begin
         add_tag(f, WIRE_FIXED32);
         add_bytes(4);
      end else if (k < 70) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
         add_tag(f, WIRE_LEN);
         add_varint(64'(len), ($urandom_range(0, 7) == 0) ? 1 : 0);
         add_bytes(len);
      end else if (k < 82) begin
         add_tag(f, WIRE_SGROUP);
         open_q = {open_q, f};
      end else if (k < 94) begin
         add_tag(open_q.pop_back(), WIRE_EGROUP);
      end else if (k < 96) begin
         // end group that most likely names the wrong field
         add_tag(f, WIRE_EGROUP);
      end else begin
         add_tag(f, $urandom_range(0, 1) ? WIRE_BAD7 : WIRE_BAD6);
      end
   endfunction

   function automatic void build_message();
      int unsigned mode;
      msg_q.delete();
      open_q.delete();
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
         add_bytes($urandom_range(1, 12));
      end else if (mode < 14) begin
         // nest right around the stack limit
         repeat ($urandom_range(GROUP_DEPTH - 1, GROUP_DEPTH + 1)) begin
            open_q = {open_q, 32'($urandom_range(1, 40))};
            add_tag(open_q[$], WIRE_SGROUP);
         end
         repeat ($urandom_range(0, 3)) add_field();
         close_groups();
      end else begin
         repeat ($urandom_range(1, 6)) add_field();
         if ($urandom_range(0, 3) != 0) close_groups();
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l);
      bit taken;
      calm = (sent_count >= CALM_FROM && sent_count < CALM_TO);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= l;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sent_count++;
      book.note_byte(b, l);
   endtask

   task automatic send_message();
      int unsigned stop;
      stop = msg_q.size();
      if ($urandom_range(0, 99) < 15) stop = $urandom_range(1, msg_q.size());
      for (int unsigned i = 0; i < stop; i++) send_byte(msg_q[i], i == stop - 1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      while (sent_count < RANDOM_ITEMS) begin
         build_message();
         send_message();
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.fails == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pbwd_pkg.sv
rtl/pbwd_group_stack.sv
rtl/pbwd_decode.sv
rtl/pbwd_out_fifo.sv
rtl/protobuf_wire_field_decoder.sv
dv/tb_protobuf_wire_field_decoder.sv
